FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL of the access statistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check prop at every clock edge while out of reset.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check prop at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/fpas_pkg.sv
// Types, constants and status codes of the access statistics block.
package fpas_pkg;

  localparam int unsigned DefStatEntries   = 1024;
  localparam int unsigned DefFilterEntries = 128;
  localparam int unsigned KeyW             = 64;
  localparam int unsigned CntW             = 64;
  localparam int unsigned ByteW            = 32;
  localparam int unsigned StatusW          = 3;

  localparam logic [StatusW-1:0] STS_NOT_FILTERED = 3'd0;
  localparam logic [StatusW-1:0] STS_ZERO_KEY     = 3'd1;
  localparam logic [StatusW-1:0] STS_TABLE_FULL   = 3'd2;
  localparam logic [StatusW-1:0] STS_COUNTED      = 3'd3;
  localparam logic [StatusW-1:0] STS_FILTER_ADDED = 3'd4;
  localparam logic [StatusW-1:0] STS_FILTER_FULL  = 3'd5;

  localparam logic CMD_ADD_FILTER = 1'b0;
  localparam logic CMD_ACCESS     = 1'b1;

  // Four counters of one entry, read count in the lowest bits.
  typedef struct packed {
    logic [CntW-1:0] write_byte_total;
    logic [CntW-1:0] write_total;
    logic [CntW-1:0] read_byte_total;
    logic [CntW-1:0] read_total;
  } counters_t;

  // Control of the statistics store for one cycle.
  typedef struct packed {
    logic key_rd;
    logic key_wr;
    logic cnt_rd;
    logic cnt_wr;
    logic cnt_clear;
    logic is_write;
  } stat_cmd_t;

endpackage

FILE: hdl/fpas_stat_store.sv
// Statistics key memory and counter memory with the counter update adders.
module fpas_stat_store #(
  parameter int unsigned STAT_ENTRIES = fpas_pkg::DefStatEntries,
  parameter int unsigned AddrW        = (STAT_ENTRIES > 1) ? $clog2(STAT_ENTRIES) : 1
) (
  input  logic                       clk_i,
  input  fpas_pkg::stat_cmd_t        cmd_i,
  input  logic [AddrW-1:0]           addr_i,
  input  logic [fpas_pkg::KeyW-1:0]  key_i,
  input  logic [fpas_pkg::ByteW-1:0] bytes_i,
  output logic [fpas_pkg::KeyW-1:0]  key_o,
  output fpas_pkg::counters_t        cnt_o
);
  import fpas_pkg::*;

  logic [KeyW-1:0] key_mem [STAT_ENTRIES];
  counters_t       cnt_mem [STAT_ENTRIES];
  counters_t       cnt_rd_q;
  counters_t       base;

  always_ff @(posedge clk_i) begin
    if (cmd_i.key_wr) begin
      key_mem[addr_i] <= key_i;
    end
    if (cmd_i.key_rd) begin
      key_o <= key_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_wr) begin
      cnt_mem[addr_i] <= cnt_o;
    end
    if (cmd_i.cnt_rd) begin
      cnt_rd_q <= cnt_mem[addr_i];
    end
  end

  // New entries start from zero; otherwise advance what was read.
  always_comb begin
    base  = cmd_i.cnt_clear ? '0 : cnt_rd_q;
    cnt_o = base;
    if (cmd_i.is_write) begin
      cnt_o.write_total      = base.write_total + CntW'(1);
      cnt_o.write_byte_total = base.write_byte_total + CntW'(bytes_i);
    end else begin
      cnt_o.read_total      = base.read_total + CntW'(1);
      cnt_o.read_byte_total = base.read_byte_total + CntW'(bytes_i);
    end
  end

endmodule

FILE: hdl/filtered_per_key_access_stats.sv
// Top level of the filtered per-key access statistics block.
//
// Requests enter on the s_axis group, one result per request leaves on the
// m_axis group. tuser of a request carries the command (add a directory key
// to the filter set, or record a file access) and the read/write flag; tdata
// carries parent directory key, file key and byte count. tuser of a result
// carries the status, tdata the four counters of the entry after the update,
// all zero unless the status is counted. Keys sit in synchronous memories
// filled from index zero upward and never freed, so a fill count marks the
// valid part. A request scans the filter memory key by key, a read state and
// then a compare state for each stored key, then (for a counted access) the
// stat key memory in the same way, then reads (for a new entry: zeroes),
// updates and writes back the counter entry. Each key memory has a single
// read port, so a scan reads one key at a time; the next request is taken
// once the result sits in the output register. Reset empties both tables at
// once by clearing the fill counts. A stalled receiver holds the result in
// the output register; a following request is then worked on but waits in
// the final state until the output register frees up.
module filtered_per_key_access_stats #(
  parameter int unsigned STAT_ENTRIES   = fpas_pkg::DefStatEntries,
  parameter int unsigned FILTER_ENTRIES = fpas_pkg::DefFilterEntries
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // parent_dir_key[63:0], file_key[127:64], byte_count[159:128]
  input  logic [159:0] s_axis_tdata_i,
  // command[0], is_write[1]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // read_total[63:0], read_byte_total[127:64], write_total[191:128],
  // write_byte_total[255:192]
  output logic [255:0] m_axis_tdata_o,
  // status[2:0]
  output logic [2:0]   m_axis_tuser_o
);
  import fpas_pkg::*;

  localparam int unsigned FAW = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
  localparam int unsigned FCW = $clog2(FILTER_ENTRIES + 1);
  localparam int unsigned SAW = (STAT_ENTRIES > 1) ? $clog2(STAT_ENTRIES) : 1;
  localparam int unsigned SCW = $clog2(STAT_ENTRIES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_F_RD  = 3'd1;
  localparam logic [2:0] S_F_CMP = 3'd2;
  localparam logic [2:0] S_T_RD  = 3'd3;
  localparam logic [2:0] S_T_CMP = 3'd4;
  localparam logic [2:0] S_C_UPD = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [FCW-1:0]     fcount_q, fcount_d, fidx_q, fidx_d;
  logic [SCW-1:0]     scount_q, scount_d, sidx_q, sidx_d;
  logic               clear_q, clear_d;
  logic               cmd_q, wr_q;
  logic [KeyW-1:0]    parent_q, file_q;
  logic [ByteW-1:0]   bytes_q;
  logic [StatusW-1:0] res_st_q, res_st_d;
  counters_t          res_cnt_q, res_cnt_d;
  logic               out_valid_q;
  logic [StatusW-1:0] out_st_q;
  counters_t          out_cnt_q;

  logic [KeyW-1:0]    filter_mem [FILTER_ENTRIES];
  logic [KeyW-1:0]    fkey_q;
  logic               f_rd, f_wr;
  logic [FAW-1:0]     f_addr;

  stat_cmd_t          scmd;
  logic [SAW-1:0]     s_addr;
  logic [KeyW-1:0]    skey;
  counters_t          upd;

  logic in_acc, out_free;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // Hold the request fields for the whole scan.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= s_axis_tuser_i[0];
      wr_q     <= s_axis_tuser_i[1];
      parent_q <= s_axis_tdata_i[63:0];
      file_q   <= s_axis_tdata_i[127:64];
      bytes_q  <= s_axis_tdata_i[159:128];
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_wr) begin
      filter_mem[f_addr] <= parent_q;
    end
    if (f_rd) begin
      fkey_q <= filter_mem[f_addr];
    end
  end

  fpas_stat_store #(
    .STAT_ENTRIES(STAT_ENTRIES)
  ) u_store (
    .clk_i  (clk_i),
    .cmd_i  (scmd),
    .addr_i (s_addr),
    .key_i  (file_q),
    .bytes_i(bytes_q),
    .key_o  (skey),
    .cnt_o  (upd)
  );

  always_comb begin
    state_d   = state_q;
    fcount_d  = fcount_q;
    fidx_d    = fidx_q;
    scount_d  = scount_q;
    sidx_d    = sidx_q;
    clear_d   = clear_q;
    res_st_d  = res_st_q;
    res_cnt_d = res_cnt_q;
    f_rd      = 1'b0;
    f_wr      = 1'b0;
    f_addr    = fidx_q[FAW-1:0];
    scmd      = '0;
    scmd.is_write  = wr_q;
    scmd.cnt_clear = clear_q;
    s_addr    = sidx_q[SAW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          fidx_d  = '0;
          state_d = S_F_RD;
        end
      end
      S_F_RD: begin
        if (fidx_q == fcount_q) begin
          // Key not in the filter set.
          res_cnt_d = '0;
          state_d   = S_DONE;
          if (cmd_q == CMD_ACCESS) begin
            res_st_d = STS_NOT_FILTERED;
          end else if (fcount_q != FCW'(FILTER_ENTRIES)) begin
            f_wr     = 1'b1;
            f_addr   = fcount_q[FAW-1:0];
            fcount_d = fcount_q + FCW'(1);
            res_st_d = STS_FILTER_ADDED;
          end else begin
            res_st_d = STS_FILTER_FULL;
          end
        end else begin
          f_rd    = 1'b1;
          state_d = S_F_CMP;
        end
      end
      S_F_CMP: begin
        if (fkey_q == parent_q) begin
          res_cnt_d = '0;
          if (cmd_q == CMD_ADD_FILTER) begin
            res_st_d = STS_FILTER_ADDED;
            state_d  = S_DONE;
          end else if (file_q == '0) begin
            res_st_d = STS_ZERO_KEY;
            state_d  = S_DONE;
          end else begin
            sidx_d  = '0;
            state_d = S_T_RD;
          end
        end else begin
          fidx_d  = fidx_q + FCW'(1);
          state_d = S_F_RD;
        end
      end
      S_T_RD: begin
        if (sidx_q == scount_q) begin
          if (scount_q != SCW'(STAT_ENTRIES)) begin
            // Insert at the next free entry with zeroed counters.
            scmd.key_wr = 1'b1;
            s_addr      = scount_q[SAW-1:0];
            scount_d    = scount_q + SCW'(1);
            clear_d     = 1'b1;
            state_d     = S_C_UPD;
          end else begin
            res_st_d = STS_TABLE_FULL;
            state_d  = S_DONE;
          end
        end else begin
          scmd.key_rd = 1'b1;
          state_d     = S_T_CMP;
        end
      end
      S_T_CMP: begin
        if (skey == file_q) begin
          scmd.cnt_rd = 1'b1;
          clear_d     = 1'b0;
          state_d     = S_C_UPD;
        end else begin
          sidx_d  = sidx_q + SCW'(1);
          state_d = S_T_RD;
        end
      end
      S_C_UPD: begin
        scmd.cnt_wr = 1'b1;
        res_cnt_d   = upd;
        res_st_d    = STS_COUNTED;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fcount_q <= '0;
      scount_q <= '0;
      fidx_q   <= '0;
      sidx_q   <= '0;
      clear_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fcount_q <= fcount_d;
      scount_q <= scount_d;
      fidx_q   <= fidx_d;
      sidx_q   <= sidx_d;
      clear_q  <= clear_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_st_q  <= res_st_d;
    res_cnt_q <= res_cnt_d;
  end

  // Output register: load from the final state, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_st_q  <= res_st_q;
      out_cnt_q <= res_cnt_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_cnt_q;
  assign m_axis_tuser_o  = out_st_q;

`include "assert_macros.svh"

  `ASSERT_RST(a_fcount_range, clk_i, rst_ni, fcount_q <= FCW'(FILTER_ENTRIES), "filter fill overrun")
  `ASSERT_RST(a_scount_range, clk_i, rst_ni, scount_q <= SCW'(STAT_ENTRIES), "table fill overrun")
  `ASSERT_RST(a_uncounted_zero, clk_i, rst_ni, (out_valid_q && out_st_q != STS_COUNTED) |-> (out_cnt_q == '0), "uncounted result has nonzero counters")

endmodule
